@@ rtl/core/dbcs_cl_pkg.sv @@
// shared types, codes and constants for the two-byte character locate/step core
// no dependencies

package dbcs_cl_pkg;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_SUBBOOK = 2'd1,
		ST_NO_CHAR    = 2'd2,
		ST_NO_FONT    = 2'd3
	} status_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_SUBBOOK    = 3'd0,
		REG_CHARSET    = 3'd1,
		REG_FONT_PAGE  = 3'd2,
		REG_FONT_START = 3'd3,
		REG_FONT_END   = 3'd4
	} reg_idx_t;

	localparam int unsigned PIPE_DEPTH = 5;

	localparam logic [7:0] CELL_LO_JIS   = 8'h21;
	localparam logic [7:0] CELL_HI_JIS   = 8'h7e;
	localparam logic [7:0] ROW_JIS       = 8'h5e;
	localparam logic [7:0] CELL_LO_LATIN = 8'h01;
	localparam logic [7:0] CELL_HI_LATIN = 8'hfe;
	localparam logic [7:0] ROW_LATIN     = 8'hfe;

	// linear position and reciprocal divide widths
	localparam int unsigned POS_W       = 17;
	localparam int unsigned RECIP_SHIFT = 18;
	localparam int unsigned RECIP_W     = 12;
	localparam int unsigned PROD_W      = POS_W + RECIP_W;
	localparam int unsigned QUO_W       = PROD_W - RECIP_SHIFT;
	localparam int unsigned REM_W       = 9;
	localparam int unsigned RES_W       = QUO_W + 9;

	localparam logic [RECIP_W-1:0] RECIP_JIS   = RECIP_W'((1 << RECIP_SHIFT) / ROW_JIS);
	localparam logic [RECIP_W-1:0] RECIP_LATIN = RECIP_W'((1 << RECIP_SHIFT) / ROW_LATIN);

	typedef struct packed {
		logic        sub_sel;
		logic        latin;
		logic [15:0] font_page;
		logic [15:0] font_start;
		logic [15:0] font_end;
	} cfg_t;

	// request state leaving the front stages
	typedef struct packed {
		logic                    cmd_step;
		logic                    bwd;
		logic                    fail;
		status_t                 status;
		logic [POS_W-1:0]        pos;
		logic signed [17:0]      idx;
	} front_t;

	// request state leaving the divide / offset stages
	typedef struct packed {
		logic                    cmd_step;
		logic                    bwd;
		logic                    fail;
		status_t                 status;
		logic [QUO_W-1:0]        quo;
		logic [REM_W-1:0]        rem;
		logic [31:0]             loc;
	} back_t;

	function automatic logic [7:0] cell_lo(input logic latin);
		return latin ? CELL_LO_LATIN : CELL_LO_JIS;
	endfunction

	function automatic logic [7:0] cell_hi(input logic latin);
		return latin ? CELL_HI_LATIN : CELL_HI_JIS;
	endfunction

	function automatic logic [7:0] row_cells(input logic latin);
		return latin ? ROW_LATIN : ROW_JIS;
	endfunction

	function automatic logic [RECIP_W-1:0] row_recip(input logic latin);
		return latin ? RECIP_LATIN : RECIP_JIS;
	endfunction

endpackage

@@ rtl/core/dbcs_char_locate_and_step_core.sv @@
// top level of the two-byte character locate/step core: config registers,
// front and back stages, final range check and result register
// depends on dbcs_cl_pkg, dbcs_cl_front, dbcs_cl_back

// A request is taken in every cycle that start is high; busy is always low.
// Each request gives exactly one result, shown with done for one cycle, in
// request order. The five stages are: code
// checks and row products, linear position, reciprocal multiply and record
// offset multiply, remainder, and the final correction with range check.
// Configuration writes are taken at once (cfg_ready is always high) and
// must be made while no request is in flight.

module dbcs_char_locate_and_step_core #(
	parameter int unsigned PAGE_BYTES   = 2048,
	parameter int unsigned RECORD_BYTES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic [15:0]        char_code,
	input  logic signed [16:0] step_count,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [16:0] new_code,
	output logic [31:0]        location,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import dbcs_cl_pkg::*;

	cfg_t             cfg_q;
	logic             vld_s2;
	front_t           front_s2;
	logic             vld_s4;
	back_t            back_s4;

	logic [7:0]       per;
	logic [QUO_W-1:0] quo;
	logic [REM_W-1:0] rem;
	logic [RES_W-1:0] res;
	logic             range_fail;
	logic             ok;

	logic             done_s5;
	status_t          status_s5;
	logic [16:0]      new_code_s5;
	logic [31:0]      location_s5;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SUBBOOK:    cfg_q.sub_sel    <= cfg_data[0];
				REG_CHARSET:    cfg_q.latin      <= cfg_data[0];
				REG_FONT_PAGE:  cfg_q.font_page  <= cfg_data;
				REG_FONT_START: cfg_q.font_start <= cfg_data;
				REG_FONT_END:   cfg_q.font_end   <= cfg_data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	dbcs_cl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_vld     (start && !busy),
		.command    (command),
		.char_code  (char_code),
		.step_count (step_count),
		.vld_s2     (vld_s2),
		.front_s2   (front_s2)
	);

	dbcs_cl_back #(
		.PAGE_BYTES   (PAGE_BYTES),
		.RECORD_BYTES (RECORD_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.vld_s2   (vld_s2),
		.front_s2 (front_s2),
		.vld_s4   (vld_s4),
		.back_s4  (back_s4)
	);

	assign per = row_cells(cfg_q.latin);

	always_comb begin
		quo = back_s4.quo;
		rem = back_s4.rem;
		if (rem >= REM_W'(per)) begin
			quo = back_s4.quo + QUO_W'(1);
			rem = back_s4.rem - REM_W'(per);
		end
	end

	assign res = {quo, 8'h00} + RES_W'(rem) + RES_W'(cell_lo(cfg_q.latin));

	// forward moves only grow the code, backward moves only shrink it
	assign range_fail = back_s4.bwd ? (res < RES_W'(cfg_q.font_start))
		: (res > RES_W'(cfg_q.font_end));
	assign ok = !back_s4.fail && !(back_s4.cmd_step && range_fail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5 <= 1'b0;
		end else begin
			done_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		status_s5   <= ok ? ST_OK : (back_s4.fail ? back_s4.status : ST_NO_CHAR);
		new_code_s5 <= (ok && back_s4.cmd_step) ? res[16:0] : '1;
		location_s5 <= (ok && !back_s4.cmd_step) ? back_s4.loc : 32'd0;
	end

	assign done     = done_s5;
	assign status   = status_s5;
	assign new_code = $signed(new_code_s5);
	assign location = location_s5;

endmodule

@@ rtl/core/dbcs_cl_front.sv @@
// front stages: code checks, row products, linear position and record index
// depends on dbcs_cl_pkg

module dbcs_cl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  dbcs_cl_pkg::cfg_t   cfg,
	input  logic                in_vld,
	input  logic                command,
	input  logic [15:0]         char_code,
	input  logic signed [16:0]  step_count,
	output logic                vld_s2,
	output dbcs_cl_pkg::front_t front_s2
);
	import dbcs_cl_pkg::*;

	logic [7:0]         row;
	logic [7:0]         code_cell;
	logic [7:0]         lo;
	logic [7:0]         hi;
	logic [7:0]         per;
	logic               bwd_c;
	logic               code_ok;
	logic               fail_c;
	status_t            status_c;
	logic signed [8:0]  rowdiff;

	logic               vld_s1;
	logic               cmd_s1;
	logic               bwd_s1;
	logic               fail_s1;
	status_t            status_s1;
	logic signed [16:0] count_s1;
	logic [15:0]        row_prod_s1;
	logic [7:0]         cell_off_s1;
	logic signed [16:0] rowdiff_prod_s1;
	logic signed [8:0]  celldiff_s1;

	logic signed [17:0] pos_c;
	logic signed [17:0] idx_c;
	front_t             front_c;

	assign row       = char_code[15:8];
	assign code_cell = char_code[7:0];
	assign lo        = cell_lo(cfg.latin);
	assign hi        = cell_hi(cfg.latin);
	assign per       = row_cells(cfg.latin);
	assign bwd_c     = command && step_count[16];
	assign code_ok   = (char_code >= cfg.font_start) && (char_code <= cfg.font_end)
		&& (code_cell >= lo) && (code_cell <= hi);
	assign rowdiff   = $signed({1'b0, row}) - $signed({1'b0, cfg.font_start[15:8]});

	always_comb begin
		fail_c   = 1'b1;
		status_c = ST_NO_CHAR;
		priority if (!cfg.sub_sel) begin
			status_c = ST_NO_SUBBOOK;
		end else if (cfg.font_page == 16'd0) begin
			status_c = bwd_c ? ST_NO_FONT : ST_NO_CHAR;
		end else if (!code_ok) begin
			status_c = ST_NO_CHAR;
		end else begin
			fail_c   = 1'b0;
			status_c = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1          <= command;
		bwd_s1          <= bwd_c;
		fail_s1         <= fail_c;
		status_s1       <= status_c;
		count_s1        <= step_count;
		row_prod_s1     <= 16'(16'(row) * 16'(per));
		cell_off_s1     <= code_cell - lo;
		rowdiff_prod_s1 <= 17'(17'(rowdiff) * 17'($signed({1'b0, per})));
		celldiff_s1     <= $signed({1'b0, code_cell}) - $signed({1'b0, cfg.font_start[7:0]});
	end

	// position counted in legal cells from row 0
	assign pos_c = $signed({2'b00, row_prod_s1}) + $signed({10'd0, cell_off_s1})
		+ 18'(count_s1);
	assign idx_c = 18'(rowdiff_prod_s1) + 18'(celldiff_s1);

	always_comb begin
		front_c.cmd_step = cmd_s1;
		front_c.bwd      = bwd_s1;
		front_c.fail     = fail_s1;
		front_c.status   = status_s1;
		front_c.pos      = pos_c[POS_W-1:0];
		front_c.idx      = idx_c;
		if (!fail_s1 && cmd_s1 && pos_c[17]) begin
			front_c.fail   = 1'b1;
			front_c.status = ST_NO_CHAR;
		end
	end

	always_ff @(posedge clk) begin
		front_s2 <= front_c;
	end

endmodule

@@ rtl/core/dbcs_cl_back.sv @@
// middle stages: reciprocal divide by row length and record byte offset
// depends on dbcs_cl_pkg

module dbcs_cl_back #(
	parameter int unsigned PAGE_BYTES   = 2048,
	parameter int unsigned RECORD_BYTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dbcs_cl_pkg::cfg_t   cfg,
	input  logic                vld_s2,
	input  dbcs_cl_pkg::front_t front_s2,
	output logic                vld_s4,
	output dbcs_cl_pkg::back_t  back_s4
);
	import dbcs_cl_pkg::*;

	logic                vld_s3;
	logic                cmd_s3;
	logic                bwd_s3;
	logic                fail_s3;
	status_t             status_s3;
	logic [POS_W-1:0]    pos_s3;
	logic [PROD_W-1:0]   prod_s3;
	logic [31:0]         rec_s3;
	logic [31:0]         page_base_s3;

	logic [QUO_W-1:0]    quo_est;
	logic [17:0]         rem_full;
	back_t               back_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s3       <= front_s2.cmd_step;
		bwd_s3       <= front_s2.bwd;
		fail_s3      <= front_s2.fail;
		status_s3    <= front_s2.status;
		pos_s3       <= front_s2.pos;
		prod_s3      <= PROD_W'(PROD_W'(front_s2.pos) * PROD_W'(row_recip(cfg.latin)));
		rec_s3       <= 32'(32'(front_s2.idx) * 32'(RECORD_BYTES));
		page_base_s3 <= 32'(32'(cfg.font_page - 16'd1) * 32'(PAGE_BYTES));
	end

	// quotient estimate is low by at most one, fixed in the last stage
	assign quo_est  = prod_s3[RECIP_SHIFT +: QUO_W];
	assign rem_full = 18'(pos_s3) - 18'(18'(quo_est) * 18'(row_cells(cfg.latin)));

	always_comb begin
		back_c.cmd_step = cmd_s3;
		back_c.bwd      = bwd_s3;
		back_c.fail     = fail_s3;
		back_c.status   = status_s3;
		back_c.quo      = quo_est;
		back_c.rem      = rem_full[REM_W-1:0];
		back_c.loc      = page_base_s3 + rec_s3;
	end

	always_ff @(posedge clk) begin
		back_s4 <= back_c;
	end

endmodule

@@ rtl/core/dbcs_cl_checker.sv @@
// port-level checks for the locate/step core, bound to the top level
// depends on dbcs_cl_pkg and dbcs_char_locate_and_step_core

module dbcs_cl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               command,
	input logic signed [16:0] step_count,
	input logic               done,
	input logic [1:0]         status,
	input logic signed [16:0] new_code,
	input logic [31:0]        location
);
	import dbcs_cl_pkg::*;

	// every request gives a result after the fixed latency
	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_DEPTH done)
		else $error("request without result");

	// no result without a matching request
	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_DEPTH))
		else $error("result without request");

	// failures carry no code and no location
	a_fail_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (new_code == -17'sd1 && location == 32'd0))
		else $error("failed request with payload");

	// missing font status only for a backward step
	a_no_font_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_NO_FONT) |-> $past(command && step_count[16], PIPE_DEPTH))
		else $error("no-font status on a non-backward request");

endmodule

bind dbcs_char_locate_and_step_core dbcs_cl_checker u_dbcs_cl_checker (.*);

@@ bench/tb_dbcs_char_locate_and_step_core.sv @@
// self-checking testbench for dbcs_char_locate_and_step_core: directed and random requests,
// each result checked against a behavioral predictor of locate and step
// depends on dbcs_cl_pkg and the core rtl
`timescale 1ns / 1ps

module tb_dbcs_char_locate_and_step_core;
	import dbcs_cl_pkg::*;

	localparam int PAGE_BYTES   = 2048;
	localparam int RECORD_BYTES = 32;
	localparam int LIMIT_CYCLES = 200000;
	localparam int MAX_REPORTS  = 10;
	localparam int PHASE_ITEMS  = 321;

	localparam logic CMD_LOCATE = 1'b0;
	localparam logic CMD_STEP   = 1'b1;
	localparam logic signed [16:0] CODE_NONE = -17'sd1;

	typedef struct packed {
		status_t            st;
		logic signed [16:0] code;
		logic [31:0]        loc;
	} lookup_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               command = CMD_LOCATE;
	logic [15:0]        char_code = '0;
	logic signed [16:0] step_count = '0;
	logic               done;
	logic [1:0]         status;
	logic signed [16:0] new_code;
	logic [31:0]        location;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	cfg_t           model_cfg = '0;
	lookup_result_t pending_results[$];
	int             mismatches = 0;
	int             cycle_count = 0;
	int             gap_pct = 0;

	dbcs_char_locate_and_step_core #(
		.PAGE_BYTES  (PAGE_BYTES),
		.RECORD_BYTES(RECORD_BYTES)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.char_code (char_code),
		.step_count(step_count),
		.done      (done),
		.status    (status),
		.new_code  (new_code),
		.location  (location),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic lookup_result_t predict_lookup(input logic cmd, input logic [15:0] code,
			input logic signed [16:0] count);
		lookup_result_t r;
		longint lo, hi, per, row, cel, pos, nxt, pg, f_lo, f_hi;
		logic bwd;
		lo   = model_cfg.latin ? CELL_LO_LATIN : CELL_LO_JIS;
		hi   = model_cfg.latin ? CELL_HI_LATIN : CELL_HI_JIS;
		per  = model_cfg.latin ? ROW_LATIN : ROW_JIS;
		row  = code[15:8];
		cel  = code[7:0];
		pg   = model_cfg.font_page;
		f_lo = model_cfg.font_start;
		f_hi = model_cfg.font_end;
		bwd  = (cmd == CMD_STEP) && (count < 0);
		r.st   = ST_NO_CHAR;
		r.code = CODE_NONE;
		r.loc  = '0;
		if (!model_cfg.sub_sel) begin
			r.st = ST_NO_SUBBOOK;
		end else if (pg == 0) begin
			r.st = bwd ? ST_NO_FONT : ST_NO_CHAR;
		end else if (code < f_lo || code > f_hi || cel < lo || cel > hi) begin
			r.st = ST_NO_CHAR;
		end else if (cmd == CMD_LOCATE) begin
			// linear index can go negative when the start cell is not legal
			pos = (row - longint'(model_cfg.font_start[15:8])) * per + cel
				- longint'(model_cfg.font_start[7:0]);
			r.st  = ST_OK;
			r.loc = 32'((pg - 1) * PAGE_BYTES + pos * RECORD_BYTES);
		end else begin
			pos = row * per + cel - lo + count;
			if (pos >= 0) begin
				nxt = (pos / per) * 256 + pos % per + lo;
				if (!((!bwd && nxt > f_hi) || (bwd && nxt < f_lo))) begin
					r.st   = ST_OK;
					r.code = 17'(nxt);
				end
			end
		end
		return r;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// results are stable mid-cycle and are checked at the falling edge
	always @(negedge clk) begin
		lookup_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result status %0d code %0d loc %h",
					status, new_code, location));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					note_mismatch($sformatf("status exp %0d got %0d", want.st, status));
				if (new_code !== want.code)
					note_mismatch($sformatf("new_code exp %0d got %0d", want.code, new_code));
				if (location !== want.loc)
					note_mismatch($sformatf("location exp %h got %h", want.loc, location));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("dbcs_char_locate_and_step_core test failed");
			$finish;
		end
	end

	task automatic send_request(input logic cmd, input logic [15:0] code,
			input logic signed [16:0] count);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		command    <= cmd;
		char_code  <= code;
		step_count <= count;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		pending_results.push_back(predict_lookup(cmd, code, count));
	endtask

	task automatic drain_requests();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes need one assignment per edge
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		case (idx)
			REG_SUBBOOK:    model_cfg.sub_sel    = data[0];
			REG_CHARSET:    model_cfg.latin      = data[0];
			REG_FONT_PAGE:  model_cfg.font_page  = data;
			REG_FONT_START: model_cfg.font_start = data;
			REG_FONT_END:   model_cfg.font_end   = data;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic sub, input logic latin, input logic [15:0] page,
			input logic [15:0] f_lo, input logic [15:0] f_hi);
		drain_requests();
		write_reg(REG_SUBBOOK, {15'($urandom), sub});
		write_reg(REG_CHARSET, {15'($urandom), latin});
		write_reg(REG_FONT_PAGE, page);
		write_reg(REG_FONT_START, f_lo);
		write_reg(REG_FONT_END, f_hi);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_state();
		gap_pct = 0;
		send_request(CMD_LOCATE, 16'h2121, 17'sd0);
		send_request(CMD_STEP, 16'h2121, 17'sd1);
		send_request(CMD_STEP, 16'h2121, -17'sd1);
	endtask

	// writes to indexes past the last register must leave everything alone
	task automatic test_spare_indexes();
		drain_requests();
		for (int k = 1; k <= 3; k++)
			write_reg(3'(REG_FONT_END + k), 16'hffff);
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_request(CMD_LOCATE, 16'h0001, 17'sd0);
	endtask

	task automatic test_jis_bounds();
		set_config(1'b1, 1'b0, 16'd2, 16'h2121, 16'h7e7e);
		send_request(CMD_LOCATE, 16'h2121, 17'sd0);
		send_request(CMD_LOCATE, 16'h7e7e, -17'sd5);
		send_request(CMD_LOCATE, 16'h2120, 17'sd0);
		send_request(CMD_LOCATE, 16'h217f, 17'sd0);
		send_request(CMD_LOCATE, 16'h0000, 17'sd0);
		send_request(CMD_LOCATE, 16'hffff, 17'sd0);
		// row wrap in both directions
		send_request(CMD_STEP, 16'h217e, 17'sd1);
		send_request(CMD_STEP, 16'h2221, -17'sd1);
		send_request(CMD_STEP, 16'h2121, 17'sd0);
		send_request(CMD_STEP, 16'h7e7e, 17'sd1);
		send_request(CMD_STEP, 16'h2121, -17'sd1);
		send_request(CMD_STEP, 16'h2121, 17'sd65535);
		send_request(CMD_STEP, 16'h7e7e, -17'sd65536);
	endtask

	task automatic test_no_font();
		set_config(1'b1, 1'b0, 16'd0, 16'h2121, 16'h7e7e);
		send_request(CMD_LOCATE, 16'h3030, 17'sd0);
		send_request(CMD_STEP, 16'h3030, 17'sd1);
		send_request(CMD_STEP, 16'h3030, -17'sd1);
	endtask

	task automatic test_latin_cells();
		set_config(1'b1, 1'b1, 16'hffff, 16'h0001, 16'hfffe);
		send_request(CMD_LOCATE, 16'h0001, 17'sd0);
		send_request(CMD_LOCATE, 16'hfffe, 17'sd0);
		send_request(CMD_LOCATE, 16'h0100, 17'sd0);
		send_request(CMD_LOCATE, 16'h01ff, 17'sd0);
		send_request(CMD_STEP, 16'h0001, -17'sd1);
		send_request(CMD_STEP, 16'h00fe, 17'sd1);
	endtask

	// illegal start cell gives a negative index and a wrapped offset
	task automatic test_offset_wrap();
		set_config(1'b1, 1'b0, 16'd1, 16'h21f0, 16'hffff);
		send_request(CMD_LOCATE, 16'h2221, 17'sd0);
	endtask

	task automatic random_config();
		logic [15:0] page, f_lo, f_hi, a, b;
		logic latin;
		logic [7:0] lo, hi;
		latin = 1'($urandom);
		lo = latin ? CELL_LO_LATIN : CELL_LO_JIS;
		hi = latin ? CELL_HI_LATIN : CELL_HI_JIS;
		case ($urandom_range(0, 7))
			0: page = 16'd0;
			1: page = 16'd1;
			2: page = 16'hffff;
			default: page = 16'($urandom);
		endcase
		a = 16'($urandom);
		b = 16'($urandom);
		case ($urandom_range(0, 7))
			0: begin f_lo = 16'h0000; f_hi = 16'hffff; end
			1: begin f_lo = 16'hffff; f_hi = 16'hffff; end
			2: begin f_lo = a; f_hi = (a > b) ? a : b; end
			3: begin f_lo = (a > b) ? a : b; f_hi = (a > b) ? b : a; end
			4: begin f_lo = a; f_hi = a + 16'($urandom_range(0, 600)); end
			default: begin
				f_lo = {(a[15:8] < b[15:8]) ? a[15:8] : b[15:8], lo};
				f_hi = {(a[15:8] < b[15:8]) ? b[15:8] : a[15:8], hi};
			end
		endcase
		if (f_hi < f_lo && $urandom_range(0, 3) != 0)
			f_hi = f_lo;
		set_config($urandom_range(0, 9) != 0, latin, page, f_lo, f_hi);
	endtask

	task automatic random_request();
		logic cmd;
		logic [15:0] code;
		logic signed [16:0] count;
		int span, lo, hi, per;
		cmd = 1'($urandom);
		lo  = model_cfg.latin ? CELL_LO_LATIN : CELL_LO_JIS;
		hi  = model_cfg.latin ? CELL_HI_LATIN : CELL_HI_JIS;
		per = model_cfg.latin ? ROW_LATIN : ROW_JIS;
		span = int'(model_cfg.font_end) - int'(model_cfg.font_start);
		if ($urandom_range(0, 9) < 2 || span < 0) begin
			code = 16'($urandom);
		end else begin
			code = 16'(int'(model_cfg.font_start) + $urandom_range(0, span));
			code[7:0] = 8'(lo + $urandom_range(0, hi - lo));
		end
		case ($urandom_range(0, 9))
			0: count = 17'($urandom);
			1, 2: count = 17'(int'($urandom_range(0, 6 * per)) - 3 * per);
			default: count = 17'(int'($urandom_range(0, 40)) - 20);
		endcase
		send_request(cmd, code, count);
	endtask

	task automatic test_random_phases();
		int pcts[6] = '{0, 70, 9, 0, 70, 9};
		for (int p = 0; p < 6; p++) begin
			random_config();
			gap_pct = pcts[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// an idle-free run now and then inside the idling phases
				if (pcts[p] != 0 && n % 64 == 0)
					gap_pct = ($urandom_range(0, 3) == 0) ? 0 : pcts[p];
				random_request();
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_spare_indexes();
		test_jis_bounds();
		test_no_font();
		test_latin_cells();
		test_offset_wrap();
		test_random_phases();
		drain_requests();
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("dbcs_char_locate_and_step_core test passed");
		end else begin
			$display("dbcs_char_locate_and_step_core test failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/dbcs_cl_pkg.sv
rtl/core/dbcs_cl_front.sv
rtl/core/dbcs_cl_back.sv
rtl/core/dbcs_char_locate_and_step_core.sv
rtl/core/dbcs_cl_checker.sv
bench/tb_dbcs_char_locate_and_step_core.sv
